// ----- rtl/sses_pkg.sv -----
// Shared types and constants for the descending exchange sorter.
// No dependencies; imported by every module of the block but sses_ram.
package sses_pkg;

  localparam int STRENGTH_W      = 8;
  localparam int SLOT_W          = 4;
  localparam int MAX_ENTRIES_DEF = 16;

  typedef struct packed {
    logic [STRENGTH_W-1:0] key;
    logic [SLOT_W-1:0]     slot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_RD,
    ST_SEED_LD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;
    logic begin_sort;
    logic seed_rd;
    logic seed_ld;
    logic scan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
  } dp_stat_t;

endpackage

// ----- rtl/sses_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sses_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sses_datapath.sv -----
// Datapath: entry RAM, fill count, pass and scan indexes, current entry.
// Depends on sses_pkg and sses_ram; driven by sses_ctrl commands.
module sses_datapath #(
  parameter int MAX_ENTRIES = sses_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sses_pkg::dp_cmd_t                      cmd,
  output sses_pkg::dp_stat_t                     stat,
  input  logic signed [sses_pkg::STRENGTH_W-1:0] in_signal_strength,
  output logic signed [sses_pkg::STRENGTH_W-1:0] out_sorted_strength,
  output logic [sses_pkg::SLOT_W-1:0]            out_original_slot,
  output logic                                   out_end_of_list
);

  import sses_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  entry_t        cur_r, cur_nxt;

  logic [CW-1:0] i_inc, j_inc;
  logic          wen;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;
  logic          greater;

  sses_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .wen  (wen),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign i_inc   = i_r + CW'(1);
  assign j_inc   = j_r + CW'(1);
  assign greater = $signed(rdata.key) > $signed(cur_r.key);

  assign stat.i_last = (i_inc == fill_r);
  assign stat.j_last = (j_inc == fill_r);

  always_comb begin
    wen        = 1'b0;
    waddr      = fill_r[AW-1:0];
    wdata.key  = in_signal_strength;
    wdata.slot = SLOT_W'(fill_r);
    raddr      = i_r[AW-1:0];
    fill_nxt   = fill_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    cur_nxt    = cur_r;
    if (cmd.store && (fill_r < CW'(MAX_ENTRIES))) begin
      wen      = 1'b1;
      fill_nxt = fill_r + CW'(1);
    end
    if (cmd.begin_sort) begin
      i_nxt = '0;
    end
    if (cmd.seed_rd) begin
      raddr = i_r[AW-1:0];
    end
    if (cmd.seed_ld) begin
      cur_nxt = rdata;
      j_nxt   = i_inc;
      raddr   = i_inc[AW-1:0];
    end
    if (cmd.scan) begin
      if (greater) begin
        wen     = 1'b1;
        waddr   = j_r[AW-1:0];
        wdata   = cur_r;
        cur_nxt = rdata;
      end
      j_nxt = j_inc;
      raddr = j_inc[AW-1:0];
    end
    if (cmd.emit) begin
      i_nxt = i_inc;
      raddr = i_inc[AW-1:0];
      if (stat.i_last) begin
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      i_r    <= '0;
      j_r    <= '0;
    end else begin
      fill_r <= fill_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_sorted_strength = cur_r.key;
  assign out_original_slot   = cur_r.slot;
  assign out_end_of_list     = stat.i_last;

endmodule

// ----- rtl/sses_ctrl.sv -----
// Controller: sequences load, exchange passes and emission.
// Depends on sses_pkg; issues commands to sses_datapath.
module sses_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_final_entry,
  input  sses_pkg::dp_stat_t stat,
  output sses_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  import sses_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_final_entry) begin
          state_nxt = ST_SEED_RD;
        end
      end
      ST_SEED_RD: state_nxt = ST_SEED_LD;
      ST_SEED_LD: state_nxt = stat.i_last ? ST_EMIT : ST_SCAN;
      ST_SCAN:    state_nxt = stat.j_last ? ST_EMIT : ST_SCAN;
      ST_EMIT:    state_nxt = stat.i_last ? ST_IDLE : ST_SEED_LD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.store      = start;
        cmd.begin_sort = start && in_final_entry;
      end
      ST_SEED_RD: cmd.seed_rd = 1'b1;
      ST_SEED_LD: cmd.seed_ld = 1'b1;
      ST_SCAN:    cmd.scan    = 1'b1;
      ST_EMIT:    cmd.emit    = 1'b1;
      default:    cmd = '0;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = cmd.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/signal_strength_exchange_sort.sv -----
// Top level of the descending exchange sorter of signal-strength readings.
// Depends on sses_pkg, sses_ctrl, sses_datapath (which holds sses_ram).
//
//   channel   transfer when          ports
//   input     start & !busy          in_signal_strength, in_final_entry
//   result    out_valid              out_sorted_strength, out_original_slot,
//                                    out_end_of_list
//
// A reading without the final mark leaves busy low.
// A final reading of an n-entry list keeps busy high until the last result;
// the passes do one compare per cycle on the single read port of the entry
// RAM, and each pass has a seed step and an emit step.
// One result leaves at the end of each pass; the receiver cannot stall.
// rst_n is synchronous, active low, and empties the list.
module signal_strength_exchange_sort #(
  parameter int MAX_ENTRIES = sses_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [sses_pkg::STRENGTH_W-1:0] in_signal_strength,
  input  logic                                   in_final_entry,
  output logic                                   out_valid,
  output logic signed [sses_pkg::STRENGTH_W-1:0] out_sorted_strength,
  output logic [sses_pkg::SLOT_W-1:0]            out_original_slot,
  output logic                                   out_end_of_list
);

  import sses_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sses_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_final_entry(in_final_entry),
    .stat          (stat),
    .cmd           (cmd),
    .busy          (busy),
    .out_valid     (out_valid)
  );

  sses_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_signal_strength (in_signal_strength),
    .out_sorted_strength(out_sorted_strength),
    .out_original_slot  (out_original_slot),
    .out_end_of_list    (out_end_of_list)
  );

endmodule
